@@ rtl/key_velocity_aftertouch_fsm_core_macros.svh @@
// Assertion macros for the key velocity and aftertouch core.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef KEY_VELOCITY_AFTERTOUCH_FSM_CORE_MACROS_SVH
`define KEY_VELOCITY_AFTERTOUCH_FSM_CORE_MACROS_SVH

// same-cycle implication
`define KVA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kva_pkg.sv @@
// Shared types, constants and the velocity curve builder for the key velocity core.
// No dependencies; imported by every module of the block.
package kva_pkg;

    localparam int NUM_KEYS_DEF       = 64;
    localparam int CURVE_GAMMA_DEF    = 20;

    localparam int KEY_W    = 6;
    localparam int POS_W    = 13;
    localparam int TS_W     = 32;
    localparam int THR_W    = 12;
    localparam int TIME_W   = 24;
    localparam int TRN_W    = 8;
    localparam int NOTE_W   = 7;
    localparam int AMT_W    = 7;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 24;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_CNT_W = 5;
    localparam int DIV_STEPS = 32;
    localparam int QUO_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_START = 3'd6;

    localparam longint VelSpan = 126;

    typedef enum logic [1:0] {
        EV_NOTE_ON    = 2'd0,
        EV_NOTE_OFF   = 2'd1,
        EV_AFTERTOUCH = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_SOUNDING = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PRESS,
        ACT_DROP,
        ACT_STRIKE,
        ACT_RELEASE,
        ACT_PRESSURE
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic act_latch;
        logic div_start;
        logic commit;
    } kva_cmd_t;

    typedef struct packed {
        action_t act;
        logic    div_done;
        logic    emit;
        logic    out_free;
    } kva_stat_t;

    typedef logic [6:0] curve_t [0:256];

    function automatic longint pow_n256(longint a, int e);
        longint r;
        r = longint'(1) << 30;
        for (int i = 0; i < e; i++)
            r = (r * a) >> 8;
        return r;
    endfunction

    function automatic longint pow_c126(longint c);
        longint r;
        r = longint'(1) << 30;
        for (int i = 0; i < 10; i++)
            r = (r * c) / VelSpan;
        return r;
    endfunction

    function automatic curve_t build_curve(int gamma_tenths);
        curve_t cv;
        longint tgt;
        int     best;
        for (int n = 0; n <= 256; n++)
        begin
            tgt  = pow_n256(longint'(n), gamma_tenths);
            best = 0;
            for (int c = 1; c <= 126; c++)
                if (pow_c126(longint'(c)) <= tgt)
                    best = c;
            cv[n] = 7'(best + 1);
        end
        return cv;
    endfunction

endpackage

@@ rtl/key_velocity_aftertouch_fsm_core.sv @@
// Key velocity and aftertouch core: one key sample per transfer, at most one MIDI event out.
// One sample at a time: no new sample is taken until the previous one commits; strikes and
// pressure first wait for the 32-step restoring divider; an event waits for a free output.
// Reset clears configuration to defaults and all key phases to idle via per-key valid flops.
// Depends on kva_pkg, kva_ctrl, kva_dp, kva_div and the macros header.
`include "key_velocity_aftertouch_fsm_core_macros.svh"
module key_velocity_aftertouch_fsm_core
    import kva_pkg::*;
#(
    parameter int NUM_KEYS           = NUM_KEYS_DEF,
    parameter int CURVE_GAMMA_TENTHS = CURVE_GAMMA_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key_number[5:0], position[18:6], timestamp[50:19]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // note[6:0], amount[13:7]
    output logic [KIND_W-1:0]     m_tuser,   // event_kind[1:0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    kva_cmd_t  cmd;
    kva_stat_t stat;

    kva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kva_dp #(
        .NUM_KEYS           (NUM_KEYS),
        .CURVE_GAMMA_TENTHS (CURVE_GAMMA_TENTHS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    `KVA_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `KVA_ASSERT_IMP(a_out_free, cmd.commit && stat.emit, stat.out_free, "result overwritten")
    `KVA_ASSERT_IMP(a_div_act, cmd.div_start,
        (stat.act == ACT_STRIKE) || (stat.act == ACT_PRESSURE), "divider started for no work")

endmodule

@@ rtl/kva_div.sv @@
// Restoring divider, one quotient bit per cycle, 32 steps.
// Depends on kva_pkg; used by the datapath.
module kva_div
    import kva_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [TIME_W-1:0]    den,
    output logic                 done,
    output logic [QUO_W-1:0]     quo,
    output logic                 ovf
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    den_reg, den_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            num_next  = num;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            q_next   = {q_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | q_reg[QUO_W-1];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign ovf  = ovf_reg;

endmodule

@@ rtl/kva_dp.sv @@
// Datapath: configuration registers, per-key memories, action decode, divider and result.
// Depends on kva_pkg and kva_div; driven by kva_ctrl through command and status structs.
module kva_dp
    import kva_pkg::*;
#(
    parameter int NUM_KEYS           = NUM_KEYS_DEF,
    parameter int CURVE_GAMMA_TENTHS = CURVE_GAMMA_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kva_cmd_t              cmd,
    output kva_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam curve_t CURVE = build_curve(CURVE_GAMMA_TENTHS);

    logic [THR_W-1:0]  press_thr_reg, strike_thr_reg, release_thr_reg, press_start_reg;
    logic [TIME_W-1:0] min_time_reg, max_time_reg;
    logic [TRN_W-1:0]  transpose_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [TS_W-1:0]   ts_reg;
    logic              bad_reg;
    phase_t            ph_rd_reg;
    logic [TS_W-1:0]   start_rd_reg;
    logic [NOTE_W-1:0] held_rd_reg;
    logic [AMT_W-1:0]  lastp_rd_reg;
    action_t           act_reg;

    phase_t            ph_mem    [NUM_KEYS];
    logic [TS_W-1:0]   start_mem [NUM_KEYS];
    logic [NOTE_W-1:0] held_mem  [NUM_KEYS];
    logic [AMT_W-1:0]  lastp_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] ph_vld_reg;

    logic                  out_valid_reg;
    event_kind_t           out_kind_reg;
    logic [NOTE_W-1:0]     out_note_reg;
    logic [AMT_W-1:0]      out_amt_reg;

    logic [KEY_W-1:0]  in_key;
    logic [7:0]        in_key_ext;
    logic [KEY_AW-1:0] rd_addr;
    logic [7:0]        key_ext;
    logic [KEY_AW-1:0] wr_addr;

    action_t           act_now;
    logic [TS_W-1:0]   d_raw, d1, d2, d3;
    logic [TIME_W-1:0] vel_span;
    logic [POS_W-1:0]  pos_excess;
    logic [19:0]       p_num;
    logic [DIV_NUM_W-1:0] div_num;
    logic [TIME_W-1:0]    div_den;
    logic                 div_done;
    logic [QUO_W-1:0]     quo;
    logic                 ovf;

    logic signed [9:0] nv;
    logic [NOTE_W-1:0] note_on;
    logic [QUO_W-1:0]  n_idx;
    logic [AMT_W-1:0]  vel;
    logic [AMT_W-1:0]  p_val;
    logic              p_moved;
    logic              emit;
    event_kind_t       res_kind;
    logic [NOTE_W-1:0] res_note;
    logic [AMT_W-1:0]  res_amt;
    logic              wr_phase;
    phase_t            wr_phase_val;

    assign in_key     = s_tdata[5:0];
    assign in_key_ext = {2'b00, in_key};
    assign rd_addr    = in_key_ext[KEY_AW-1:0];
    assign key_ext    = {2'b00, key_reg};
    assign wr_addr    = key_ext[KEY_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg   <= 12'd410;
            strike_thr_reg  <= 12'd1434;
            release_thr_reg <= 12'd205;
            min_time_reg    <= 24'd2000;
            max_time_reg    <= 24'd100000;
            transpose_reg   <= 8'd0;
            press_start_reg <= 12'd1843;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PRESS_THR:   press_thr_reg   <= cfg_wdata[THR_W-1:0];
                REG_STRIKE_THR:  strike_thr_reg  <= cfg_wdata[THR_W-1:0];
                REG_RELEASE_THR: release_thr_reg <= cfg_wdata[THR_W-1:0];
                REG_MIN_TIME:    min_time_reg    <= cfg_wdata;
                REG_MAX_TIME:    max_time_reg    <= cfg_wdata;
                REG_TRANSPOSE:   transpose_reg   <= cfg_wdata[TRN_W-1:0];
                REG_PRESS_START: press_start_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= in_key;
            pos_reg      <= s_tdata[18:6];
            ts_reg       <= s_tdata[50:19];
            bad_reg      <= in_key_ext >= 8'(NUM_KEYS);
            ph_rd_reg    <= ph_vld_reg[rd_addr] ? ph_mem[rd_addr] : PH_IDLE;
            start_rd_reg <= start_mem[rd_addr];
            held_rd_reg  <= held_mem[rd_addr];
            lastp_rd_reg <= lastp_mem[rd_addr];
        end
        if (cmd.act_latch)
            act_reg <= act_now;
    end

    always_comb
    begin
        act_now = ACT_NONE;
        if (!bad_reg)
        begin
            case (ph_rd_reg)
                PH_PRESSED:
                begin
                    if (pos_reg > {1'b0, strike_thr_reg})
                        act_now = ACT_STRIKE;
                    else if (pos_reg < {1'b0, release_thr_reg})
                        act_now = ACT_DROP;
                end
                PH_SOUNDING:
                begin
                    if (pos_reg < {1'b0, release_thr_reg})
                        act_now = ACT_RELEASE;
                    else
                        act_now = ACT_PRESSURE;
                end
                default:
                begin
                    if (pos_reg > {1'b0, press_thr_reg})
                        act_now = ACT_PRESS;
                end
            endcase
        end
    end

    always_comb
    begin
        d_raw = ts_reg - start_rd_reg;
        d1    = (d_raw == '0) ? 32'd1 : d_raw;
        d2    = (d1 < {8'd0, min_time_reg}) ? {8'd0, min_time_reg} : d1;
        d3    = (d2 > {8'd0, max_time_reg}) ? {8'd0, max_time_reg} : d2;
        vel_span   = max_time_reg - d3[TIME_W-1:0];
        pos_excess = pos_reg - {1'b0, press_start_reg};
        p_num = (pos_reg > {1'b0, press_start_reg})
              ? ({pos_excess, 7'd0} - {7'd0, pos_excess}) : '0;
        if (act_now == ACT_STRIKE)
        begin
            div_num = {vel_span, 8'd0};
            div_den = max_time_reg - min_time_reg;
        end
        else
        begin
            div_num = {12'd0, p_num};
            div_den = {11'd0, 13'd4096 - {1'b0, press_start_reg}};
        end
    end

    kva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo),
        .ovf   (ovf)
    );

    always_comb
    begin
        nv = 10'sd60 + signed'({4'b0000, key_reg}) + 10'(signed'(transpose_reg));
        if (nv < 10'sd0)
            note_on = '0;
        else if (nv > 10'sd127)
            note_on = 7'd127;
        else
            note_on = nv[NOTE_W-1:0];

        if (max_time_reg <= min_time_reg || quo > 9'd256)
            n_idx = 9'd256;
        else
            n_idx = quo;
        vel = CURVE[n_idx];

        p_val   = (ovf || quo > 9'd127) ? 7'd127 : quo[AMT_W-1:0];
        p_moved = ({1'b0, p_val} > {1'b0, lastp_rd_reg} + 8'd2)
               || ({1'b0, lastp_rd_reg} > {1'b0, p_val} + 8'd2);

        res_kind = EV_AFTERTOUCH;
        res_note = held_rd_reg;
        res_amt  = p_val;
        emit     = 1'b0;
        case (act_reg)
            ACT_STRIKE:
            begin
                res_kind = EV_NOTE_ON;
                res_note = note_on;
                res_amt  = vel;
                emit     = 1'b1;
            end
            ACT_RELEASE:
            begin
                res_kind = EV_NOTE_OFF;
                res_amt  = '0;
                emit     = 1'b1;
            end
            ACT_PRESSURE: emit = p_moved;
            default: ;
        endcase

        wr_phase     = 1'b1;
        wr_phase_val = PH_IDLE;
        case (act_reg)
            ACT_PRESS:                wr_phase_val = PH_PRESSED;
            ACT_STRIKE:               wr_phase_val = PH_SOUNDING;
            ACT_DROP, ACT_RELEASE:    wr_phase_val = PH_IDLE;
            default:                  wr_phase     = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (wr_phase)
                ph_mem[wr_addr] <= wr_phase_val;
            if (act_reg == ACT_PRESS)
                start_mem[wr_addr] <= ts_reg;
            if (act_reg == ACT_STRIKE)
            begin
                held_mem[wr_addr]  <= note_on;
                lastp_mem[wr_addr] <= '0;
            end
            else if (act_reg == ACT_PRESSURE && emit)
                lastp_mem[wr_addr] <= p_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_vld_reg <= '0;
        else if (cmd.commit && wr_phase)
            ph_vld_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            out_kind_reg <= res_kind;
            out_note_reg <= res_note;
            out_amt_reg  <= res_amt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_amt_reg, out_note_reg};
    assign m_tuser  = out_kind_reg;

    assign stat.act      = act_now;
    assign stat.div_done = div_done;
    assign stat.emit     = emit;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

@@ rtl/kva_ctrl.sv @@
// Controller state machine: sequences accept, evaluate, divide when needed, and commit.
// Depends on kva_pkg; talks to kva_dp through command and status structs.
module kva_ctrl
    import kva_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  kva_stat_t stat,
    output kva_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        needs_div;

    assign needs_div = (stat.act == ACT_STRIKE) || (stat.act == ACT_PRESSURE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL: state_next = needs_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (stat.div_done) state_next = ST_DONE;
            ST_DONE: if (!stat.emit || stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.act_latch = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EVAL:
            begin
                cmd.act_latch = 1'b1;
                cmd.div_start = needs_div;
            end
            ST_DIV: ;
            ST_DONE: cmd.commit = !stat.emit || stat.out_free;
            default: ;
        endcase
    end

endmodule
